### rtl/pdr_pkg.sv
`default_nettype none

package pdr_pkg;

    // defaults for the top level parameters
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;

    // command codes
    localparam logic [2:0] ACT_WAIT    = 3'd0;
    localparam logic [2:0] ACT_FWD     = 3'd1;
    localparam logic [2:0] ACT_LEFT    = 3'd2;
    localparam logic [2:0] ACT_RIGHT   = 3'd3;
    localparam logic [2:0] ACT_TURN    = 3'd4;
    localparam logic [2:0] ACT_MOVE    = 3'd5;
    localparam logic [2:0] ACT_GOTO    = 3'd6;
    localparam logic [2:0] ACT_RESTART = 3'd7;

    // configuration register indexes
    localparam int         CFG_IDX_W   = 3;
    localparam int         CFG_W       = 32;
    localparam logic [2:0] CFG_START_X = 3'd0;
    localparam logic [2:0] CFG_START_Y = 3'd1;
    localparam logic [2:0] CFG_MOVE_SP = 3'd2;
    localparam logic [2:0] CFG_TURN_SP = 3'd3;
    localparam logic [2:0] CFG_HIST    = 3'd4;

    // CORDIC datapath
    localparam int          XY_W       = 60;
    localparam int          GUARD_BITS = 24;
    localparam logic [29:0] GAIN_Q30   = 30'd652032874;

    // divider numerator width
    localparam int NUM_W = 49;

    // atan(2^-i) in units of 2^-32 of a turn
    localparam logic [31:0] ATAN_TURN32 [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // rounded atan step at the chosen angle resolution
    function automatic logic [31:0] atan_step(input logic [4:0] idx, input int angle_bits);
        logic [32:0] t;
        t = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - angle_bits));
        return 32'(t >> (32 - angle_bits));
    endfunction

endpackage

`default_nettype wire

### rtl/pdr_cmd_if.sv
`default_nettype none

interface pdr_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [31:0]        duration;
    logic signed [15:0] turn_angle;
    logic [31:0]        move_distance;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;

    modport source (
        output valid, action, duration, turn_angle, move_distance, target_x, target_y,
        input  ready
    );
    modport sink (
        input  valid, action, duration, turn_angle, move_distance, target_x, target_y,
        output ready
    );
endinterface

`default_nettype wire

### rtl/pdr_pose_if.sv
`default_nettype none

interface pdr_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    logic [31:0]        elapsed_time;
    logic               recorded;
    logic               last_of_run;

    modport source (
        output valid, pose_x, pose_y, pose_heading, elapsed_time, recorded, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, pose_x, pose_y, pose_heading, elapsed_time, recorded, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

### rtl/pdr_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle, quotient saturated to 32 bits
module pdr_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [pdr_pkg::NUM_W-1:0]  i_num,
    input  wire logic [31:0]                i_den,
    output logic                            o_done,
    output logic [31:0]                     o_quot
);
    localparam int NW = pdr_pkg::NUM_W;
    localparam int CW = $clog2(NW);

    logic [NW-1:0] r_num;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;
    logic [32:0]   trial;
    logic          take;

    always_comb begin
        trial = {r_rem, r_num[NW-1]};
        take  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= take ? 32'(trial - {1'b0, r_den}) : trial[31:0];
                r_num <= {r_num[NW-2:0], take};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (|r_num[NW-1:32]) ? '1 : r_num[31:0];

endmodule

`default_nettype wire

### rtl/pdr_cordic.sv
`default_nettype none

// iterative CORDIC: rotation gives (cos, sin) of a heading in Q30,
// vectoring gives the bearing and the scaled length of (dx, dy)
module pdr_cordic #(
    parameter int STEPS      = pdr_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS = pdr_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic                             i_vector,
    input  wire logic [15:0]                      i_heading,
    input  wire logic signed [32:0]               i_dx,
    input  wire logic signed [32:0]               i_dy,
    output logic                                  o_done,
    output logic signed [pdr_pkg::XY_W-1:0]       o_x,
    output logic signed [pdr_pkg::XY_W-1:0]       o_y,
    output logic [15:0]                           o_bearing
);
    localparam int XW     = pdr_pkg::XY_W;
    localparam int ZW     = ANGLE_BITS + 2;
    localparam int CW     = $clog2(STEPS);
    localparam int SH_UP  = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
    localparam int SH_DN  = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam int RND    = (ANGLE_BITS > 16) ? (1 << SH_UP) / 2 : 0;

    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [CW-1:0]        r_cnt;
    logic                 r_run, r_done, r_vec, r_flip;

    logic signed [16:0]   a17, a_fold;
    logic                 flip0;
    logic signed [31:0]   a32;
    logic signed [ZW-1:0] z0, at;
    logic signed [XW-1:0] vx, vy, xs, ys;
    logic                 neg;
    logic signed [31:0]   zr;

    always_comb begin
        a17    = 17'(signed'(i_heading));
        a_fold = a17;
        flip0  = 1'b0;
        if (a17 > 17'sd16384) begin
            a_fold = a17 - 17'sd32768;
            flip0  = 1'b1;
        end else if (a17 < -17'sd16384) begin
            a_fold = a17 + 17'sd32768;
            flip0  = 1'b1;
        end
        a32 = 32'(a_fold);
        z0  = ZW'((a32 <<< SH_UP) >>> SH_DN);
        vx  = XW'(i_dx) <<< pdr_pkg::GUARD_BITS;
        vy  = XW'(i_dy) <<< pdr_pkg::GUARD_BITS;

        xs  = r_x >>> r_cnt;
        ys  = r_y >>> r_cnt;
        at  = ZW'(pdr_pkg::atan_step(5'(r_cnt), ANGLE_BITS));
        neg = r_vec ? (r_y > 0) : (r_z < 0);

        zr  = 32'(r_z) + 32'sd0 + RND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                r_run <= 1'b1;
                r_vec <= i_vector;
                if (i_vector) begin
                    r_flip <= 1'b0;
                    if (i_dx < 0) begin
                        r_x <= -vx;
                        r_y <= -vy;
                        r_z <= ZW'(1) <<< (ANGLE_BITS - 1);
                    end else begin
                        r_x <= vx;
                        r_y <= vy;
                        r_z <= '0;
                    end
                end else begin
                    r_flip <= flip0;
                    r_x    <= XW'(pdr_pkg::GAIN_Q30);
                    r_y    <= '0;
                    r_z    <= z0;
                end
            end else if (r_run) begin
                if (neg) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_x       = r_flip ? -r_x : r_x;
    assign o_y       = r_flip ? -r_y : r_y;
    assign o_bearing = 16'((zr >>> SH_UP) <<< SH_DN);

endmodule

`default_nettype wire

### rtl/planar_pose_dead_reckoning.sv
// Planar pose dead reckoning.
// Command channel i_cmd (valid/ready): one item per command (wait, forward,
// left, right, turn by angle, move distance, go to point, restart).
// Result channel o_pose (valid/ready): zero, one or two pose items per command;
// last_of_run marks the final item of a command. Zero-duration parts emit nothing.
// Config port i_cfg_we/i_cfg_idx/i_cfg_data writes start x/y, move and turn
// speed and history limit; write only while the block is idle.
// One command at a time: i_cmd.ready is high only in the idle state.
// Go to point runs vectoring, two divisions, then both motions; dropped or
// zero-duration parts finish sooner. The shared divider yields 49 quotient
// bits; one 34x34 multiplier is reused for every product.
// Reset (synchronous, active low) restores pose 0, heading 0, time 0,
// history count 1 and the default registers.
// When o_pose is stalled the finished item waits in the output register and
// the sequencer holds before the next emit until that slot frees.
`default_nettype none

module planar_pose_dead_reckoning #(
    parameter int CORDIC_STEPS = pdr_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = pdr_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    pdr_cmd_if.sink                             i_cmd,
    pdr_pose_if.source                          o_pose,
    input  wire logic                           i_cfg_we,
    input  wire logic [pdr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pdr_pkg::CFG_W-1:0]      i_cfg_data
);
    localparam int XW = pdr_pkg::XY_W;

    // sequencer states, one-hot
    typedef enum logic [21:0] {
        S_IDLE     = 22'h000001,
        S_PREP_T   = 22'h000002,
        S_DIV_T    = 22'h000004,
        S_PREP_M   = 22'h000008,
        S_DIV_M    = 22'h000010,
        S_VEC      = 22'h000020,
        S_MAG_HI   = 22'h000040,
        S_MAG_LO   = 22'h000080,
        S_MAG_END  = 22'h000100,
        S_ANG      = 22'h000200,
        S_GO       = 22'h000400,
        S_TSTART   = 22'h000800,
        S_MUL_D    = 22'h001000,
        S_ROT_GO   = 22'h002000,
        S_ROT_WAIT = 22'h004000,
        S_MUL_Y    = 22'h008000,
        S_MUL_X    = 22'h010000,
        S_ADD_X    = 22'h020000,
        S_MUL_P    = 22'h040000,
        S_TURN_ADD = 22'h080000,
        S_EMIT     = 22'h100000,
        S_NEXT     = 22'h200000
    } t_state;

    t_state r_state;

    // configuration
    logic signed [31:0] r_start_x, r_start_y;
    logic [31:0]        r_move_sp, r_turn_sp;
    logic [15:0]        r_hist_lim;

    // pose state
    logic signed [31:0] r_pos_x, r_pos_y;
    logic [15:0]        r_heading;
    logic [31:0]        r_time;
    logic [15:0]        r_hist_cnt;

    // command working registers
    logic [2:0]         r_act;      // command code
    logic [2:0]         r_t_act;    // kind of the timed motion in progress
    logic [31:0]        r_t_dur;
    logic               r_t_last;
    logic               r_phase;    // go to point: 0 turn part, 1 move part
    logic [15:0]        r_mag;
    logic               r_left;
    logic [31:0]        r_mdist;
    logic [31:0]        r_turn_dur, r_move_dur;
    logic [15:0]        r_bear;
    logic [31:0]        r_d;
    logic signed [33:0] r_c, r_s;
    logic signed [67:0] r_prod;
    logic [59:0]        r_acc;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_out_x, r_out_y;
    logic [15:0]        r_out_head;
    logic [31:0]        r_out_time;
    logic               r_out_rec, r_out_last;

    // shared units
    logic               cor_start, cor_vector, cor_done;
    logic signed [32:0] cor_dx, cor_dy;
    logic signed [XW-1:0] cor_x, cor_y;
    logic [15:0]        cor_bearing;
    logic               div_start, div_done;
    logic [pdr_pkg::NUM_W-1:0] div_num;
    logic [31:0]        div_den, div_quot;

    logic signed [33:0] mul_a, mul_b;

    // datapath helpers
    logic               accept;
    logic signed [16:0] ang17, ang_abs;
    logic signed [15:0] head_diff;
    logic signed [16:0] diff17, diff_abs;
    logic [32:0]        time_sum;
    logic [64:0]        rnd16, rnd32;
    logic [31:0]        d_sat;
    logic [15:0]        turn_p;
    logic signed [67:0] prod_rnd;
    logic signed [37:0] mstep;
    logic [58:0]        vmag;
    logic [60:0]        lo_rnd;
    logic [60:0]        psum;
    logic [61:0]        p_rnd;
    logic [31:0]        dist_sat;
    logic               slot_free;
    logic               emit_go;
    logic               rec_ok;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    pdr_cordic #(
        .STEPS      (CORDIC_STEPS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cor_start),
        .i_vector  (cor_vector),
        .i_heading (r_heading),
        .i_dx      (cor_dx),
        .i_dy      (cor_dy),
        .o_done    (cor_done),
        .o_x       (cor_x),
        .o_y       (cor_y),
        .o_bearing (cor_bearing)
    );

    pdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign accept = i_cmd.valid && (r_state == S_IDLE);

    always_comb begin
        // target offset for go to point
        cor_dx     = 33'(i_cmd.target_x) - 33'(r_pos_x);
        cor_dy     = 33'(i_cmd.target_y) - 33'(r_pos_y);
        cor_vector = (r_state == S_IDLE);
        cor_start  = (accept && i_cmd.action == pdr_pkg::ACT_GOTO
                      && !(cor_dx == 0 && cor_dy == 0)) || (r_state == S_ROT_GO);

        div_start = ((r_state == S_PREP_T) && (r_turn_sp != 0))
                 || ((r_state == S_PREP_M) && (r_move_sp != 0));
        if (r_state == S_PREP_T) begin
            div_num = {1'b0, r_mag, 32'd0} + {17'd0, r_turn_sp[31:1]};
            div_den = r_turn_sp;
        end else begin
            div_num = {1'b0, r_mdist, 16'd0} + {17'd0, r_move_sp[31:1]};
            div_den = r_move_sp;
        end

        ang17   = 17'(i_cmd.turn_angle);
        ang_abs = (ang17 < 0) ? -ang17 : ang17;

        head_diff = signed'(r_bear - r_heading);
        diff17    = 17'(head_diff);
        diff_abs  = (diff17 < 0) ? -diff17 : diff17;

        time_sum = {1'b0, r_time} + {1'b0, r_t_dur};

        // forward travel: round(speed * duration / 2^16), saturated
        rnd16 = {1'b0, r_prod[63:0]} + 65'd32768;
        d_sat = (|rnd16[64:48]) ? '1 : rnd16[47:16];
        // turn amount: round(rate * duration / 2^32), only low 16 bits matter
        rnd32  = {1'b0, r_prod[63:0]} + 65'h80000000;
        turn_p = rnd32[47:32];

        // position step: round(d * sin or cos in Q30)
        prod_rnd = r_prod + 68'sd536870912;
        mstep    = 38'(prod_rnd >>> 30);

        // vector length times CORDIC gain, in two partial products
        vmag     = (cor_x > 0) ? cor_x[58:0] : '0;
        lo_rnd   = r_prod[60:0] + 61'd536870912;
        psum     = {1'b0, r_acc} + 61'(lo_rnd[60:30]);
        p_rnd    = {1'b0, psum} + 62'd8388608;
        dist_sat = (|p_rnd[61:56]) ? '1 : p_rnd[55:24];

        case (r_state)
            S_MUL_D: begin
                mul_a = {2'b0, r_move_sp};
                mul_b = {2'b0, r_t_dur};
            end
            S_MUL_P: begin
                mul_a = {2'b0, r_turn_sp};
                mul_b = {2'b0, r_t_dur};
            end
            S_MUL_Y: begin
                mul_a = {2'b0, r_d};
                mul_b = r_s;
            end
            S_MUL_X: begin
                mul_a = {2'b0, r_d};
                mul_b = r_c;
            end
            S_MAG_HI: begin
                mul_a = {5'b0, vmag[58:30]};
                mul_b = {4'b0, pdr_pkg::GAIN_Q30};
            end
            S_MAG_LO: begin
                mul_a = {4'b0, vmag[29:0]};
                mul_b = {4'b0, pdr_pkg::GAIN_Q30};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        slot_free = !r_out_valid || o_pose.ready;
        emit_go   = (r_state == S_EMIT) && slot_free;
        rec_ok    = (r_hist_cnt < r_hist_lim);
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_move_sp   <= 32'd65536;
            r_turn_sp   <= 32'd65536;
            r_hist_lim  <= 16'd1024;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_time      <= '0;
            r_hist_cnt  <= 16'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pdr_pkg::CFG_START_X: r_start_x  <= signed'(i_cfg_data);
                    pdr_pkg::CFG_START_Y: r_start_y  <= signed'(i_cfg_data);
                    pdr_pkg::CFG_MOVE_SP: r_move_sp  <= i_cfg_data;
                    pdr_pkg::CFG_TURN_SP: r_turn_sp  <= i_cfg_data;
                    pdr_pkg::CFG_HIST:    r_hist_lim <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // output slot: a new item replaces the one leaving this edge
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_pose.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_act   <= i_cmd.action;
                        r_phase <= 1'b0;
                        case (i_cmd.action)
                            pdr_pkg::ACT_TURN: begin
                                r_mag   <= ang_abs[15:0];
                                r_left  <= (ang17 > 0);
                                r_state <= S_PREP_T;
                            end
                            pdr_pkg::ACT_MOVE: begin
                                r_mdist <= i_cmd.move_distance;
                                r_state <= S_PREP_M;
                            end
                            pdr_pkg::ACT_GOTO: begin
                                if (cor_dx == 0 && cor_dy == 0) begin
                                    // target on the position: bearing 0, no distance
                                    r_bear  <= '0;
                                    r_mdist <= '0;
                                    r_state <= S_ANG;
                                end else begin
                                    r_state <= S_VEC;
                                end
                            end
                            pdr_pkg::ACT_RESTART: begin
                                r_pos_x    <= r_start_x;
                                r_pos_y    <= r_start_y;
                                r_heading  <= '0;
                                r_time     <= '0;
                                r_hist_cnt <= '0;
                                r_t_last   <= 1'b1;
                                r_state    <= S_EMIT;
                            end
                            default: begin
                                r_t_act  <= i_cmd.action;
                                r_t_dur  <= i_cmd.duration;
                                r_t_last <= 1'b1;
                                r_state  <= S_TSTART;
                            end
                        endcase
                    end
                end
                S_VEC: begin
                    if (cor_done) begin
                        r_bear  <= cor_bearing;
                        r_state <= S_MAG_HI;
                    end
                end
                S_MAG_HI: begin
                    r_state <= S_MAG_LO;
                end
                S_MAG_LO: begin
                    r_acc   <= r_prod[59:0];
                    r_state <= S_MAG_END;
                end
                S_MAG_END: begin
                    r_mdist <= dist_sat;
                    r_state <= S_ANG;
                end
                S_ANG: begin
                    // shorter turn toward the target bearing
                    r_mag   <= diff_abs[15:0];
                    r_left  <= (diff17 > 0);
                    r_state <= S_PREP_T;
                end
                S_PREP_T: begin
                    if (r_turn_sp != 0) begin
                        r_state <= S_DIV_T;
                    end else if (r_act == pdr_pkg::ACT_GOTO) begin
                        r_turn_dur <= '0;
                        r_state    <= S_PREP_M;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV_T: begin
                    if (div_done) begin
                        r_turn_dur <= div_quot;
                        if (r_act == pdr_pkg::ACT_GOTO) begin
                            r_state <= S_PREP_M;
                        end else begin
                            r_t_act  <= r_left ? pdr_pkg::ACT_LEFT : pdr_pkg::ACT_RIGHT;
                            r_t_dur  <= div_quot;
                            r_t_last <= 1'b1;
                            r_state  <= S_TSTART;
                        end
                    end
                end
                S_PREP_M: begin
                    if (r_move_sp != 0) begin
                        r_state <= S_DIV_M;
                    end else if (r_act == pdr_pkg::ACT_GOTO) begin
                        r_move_dur <= '0;
                        r_state    <= S_GO;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV_M: begin
                    if (div_done) begin
                        r_move_dur <= div_quot;
                        if (r_act == pdr_pkg::ACT_GOTO) begin
                            r_state <= S_GO;
                        end else begin
                            r_t_act  <= pdr_pkg::ACT_FWD;
                            r_t_dur  <= div_quot;
                            r_t_last <= 1'b1;
                            r_state  <= S_TSTART;
                        end
                    end
                end
                S_GO: begin
                    // turn part is last only when the move part emits nothing
                    r_t_act  <= r_left ? pdr_pkg::ACT_LEFT : pdr_pkg::ACT_RIGHT;
                    r_t_dur  <= r_turn_dur;
                    r_t_last <= (r_move_dur == 0);
                    r_state  <= S_TSTART;
                end
                S_TSTART: begin
                    if (r_t_dur == 0) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_time <= time_sum[32] ? '1 : time_sum[31:0];
                        case (r_t_act)
                            pdr_pkg::ACT_FWD:   r_state <= S_MUL_D;
                            pdr_pkg::ACT_LEFT:  r_state <= S_MUL_P;
                            pdr_pkg::ACT_RIGHT: r_state <= S_MUL_P;
                            default:            r_state <= S_EMIT;
                        endcase
                    end
                end
                S_MUL_D: begin
                    r_state <= S_ROT_GO;
                end
                S_ROT_GO: begin
                    r_d     <= d_sat;
                    r_state <= S_ROT_WAIT;
                end
                S_ROT_WAIT: begin
                    if (cor_done) begin
                        r_c     <= cor_x[33:0];
                        r_s     <= cor_y[33:0];
                        r_state <= S_MUL_Y;
                    end
                end
                S_MUL_Y: begin
                    r_state <= S_MUL_X;
                end
                S_MUL_X: begin
                    r_pos_y <= sat32(40'(r_pos_y) + 40'(mstep));
                    r_state <= S_ADD_X;
                end
                S_ADD_X: begin
                    r_pos_x <= sat32(40'(r_pos_x) + 40'(mstep));
                    r_state <= S_EMIT;
                end
                S_MUL_P: begin
                    r_state <= S_TURN_ADD;
                end
                S_TURN_ADD: begin
                    if (r_t_act == pdr_pkg::ACT_LEFT) begin
                        r_heading <= r_heading + turn_p;
                    end else begin
                        r_heading <= r_heading - turn_p;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        if (rec_ok) begin
                            r_hist_cnt <= r_hist_cnt + 16'd1;
                        end
                        r_out_x     <= r_pos_x;
                        r_out_y     <= r_pos_y;
                        r_out_head  <= r_heading;
                        r_out_time  <= r_time;
                        r_out_rec   <= rec_ok;
                        r_out_last  <= r_t_last;
                        r_state     <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_act == pdr_pkg::ACT_GOTO && !r_phase) begin
                        r_phase  <= 1'b1;
                        r_t_act  <= pdr_pkg::ACT_FWD;
                        r_t_dur  <= r_move_dur;
                        r_t_last <= 1'b1;
                        r_state  <= S_TSTART;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready         = (r_state == S_IDLE);
    assign o_pose.valid        = r_out_valid;
    assign o_pose.pose_x       = r_out_x;
    assign o_pose.pose_y       = r_out_y;
    assign o_pose.pose_heading = signed'(r_out_head);
    assign o_pose.elapsed_time = r_out_time;
    assign o_pose.recorded     = r_out_rec;
    assign o_pose.last_of_run  = r_out_last;

endmodule

`default_nettype wire
